// ----- rtl/keyframe_color_interpolator_defines.svh -----
// ----------------------------------------------------------------------------
// keyframe color interpolator assertion macros
// shared concurrent assertion forms, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_COLOR_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_COLOR_INTERPOLATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define KCI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define KCI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KCI_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define KCI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/kci_pkg.sv -----
// ----------------------------------------------------------------------------
// kci_pkg
// types, constants and control words for the keyframe color interpolator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kci_pkg;

    localparam int MAX_KEYS  = 16;
    localparam int TIME_BITS = 32;

    localparam int KEY_IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int KCNT_W    = $clog2(MAX_KEYS + 1);
    localparam int DW        = TIME_BITS + 1;   // signed time difference
    localparam int PW        = DW + 9;          // channel term product
    localparam int NW        = TIME_BITS + 11;  // numerator of one channel

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [3:0]  key_index;
        logic [31:0] key_time;
        logic [31:0] key_argb;
        logic [31:0] current_time;
    } t_in_word;

    typedef struct packed {
        logic [31:0] color_argb;
        logic        zero_duration_error;
    } t_out_word;

    typedef enum logic [1:0] {
        RSEL_SCAN,
        RSEL_LEFT,
        RSEL_RIGHT
    } t_rd_sel;

    typedef enum logic [1:0] {
        OSEL_LEFT,
        OSEL_ERR,
        OSEL_BLEND
    } t_out_sel;

    typedef struct packed {
        logic     wr;
        logic     start;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     scan_step;
        logic     latch_l;
        logic     latch_r;
        logic     mul;
        logic     sum;
        logic     chk;
        logic     div;
        logic     next;
        logic     out_load;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic scan_hit;
        logic scan_last;
        logic left_last;
        logic dur_zero;
        logic early;
        logic div_last;
        logic ch_last;
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/kci_datapath.sv -----
// ----------------------------------------------------------------------------
// kci_datapath
// key tables, scan registers, shared multipliers and serial divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kci_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire kci_pkg::t_in_word  i_in_word,
    input  wire logic               i_cfg_valid,
    input  wire logic [4:0]         i_cfg_data,
    input  wire kci_pkg::t_cmd      i_cmd,
    output kci_pkg::t_sts           o_sts,
    output kci_pkg::t_out_word      o_out_word
);
    import kci_pkg::*;

    logic [TIME_BITS-1:0] r_mem_time [MAX_KEYS];
    logic [31:0]          r_mem_color [MAX_KEYS];

    logic [4:0]           r_key_count;
    logic [KCNT_W-1:0]    r_n;
    logic [TIME_BITS-1:0] r_cur;
    logic [TIME_BITS-1:0] r_rd_time;
    logic [31:0]          r_rd_color;
    logic [KEY_IDX_W-1:0] r_i;
    logic [KEY_IDX_W-1:0] r_left;
    logic [TIME_BITS-1:0] r_tl;
    logic [3:0][7:0]      r_cl;
    logic [3:0][7:0]      r_cr;
    logic signed [DW-1:0] r_dur;
    logic signed [DW-1:0] r_num;
    logic [1:0]           r_ch;
    logic signed [PW-1:0] r_p1;
    logic signed [PW-1:0] r_p2;
    logic signed [NW-1:0] r_nsum;
    logic [NW-1:0]        r_dabs;
    logic [NW-1:0]        r_rem;
    logic [NW-1:0]        r_dsh;
    logic [7:0]           r_q;
    logic [2:0]           r_k;
    logic [3:0][7:0]      r_blend;
    t_out_word            r_out;

    logic [KEY_IDX_W-1:0] rd_addr;
    logic [KCNT_W-1:0]    n_n;
    logic signed [8:0]    s_from;
    logic signed [8:0]    s_diff;
    logic signed [NW-1:0] s_sum;
    logic signed [NW-1:0] s_dur_ext;
    logic                 wr_ok;
    logic                 div_ge;
    logic                 sat;

    assign wr_ok = (32'(i_in_word.key_index) < MAX_KEYS);

    always_comb begin
        unique case (i_cmd.rd_sel)
            RSEL_SCAN:  rd_addr = r_i;
            RSEL_LEFT:  rd_addr = r_left;
            RSEL_RIGHT: rd_addr = r_left + KEY_IDX_W'(1);
            default:    rd_addr = r_i;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && wr_ok) begin
            r_mem_time[KEY_IDX_W'(i_in_word.key_index)]  <= TIME_BITS'(i_in_word.key_time);
            r_mem_color[KEY_IDX_W'(i_in_word.key_index)] <= i_in_word.key_argb;
        end
        if (i_cmd.rd_en) begin
            r_rd_time  <= r_mem_time[rd_addr];
            r_rd_color <= r_mem_color[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= 5'd1;
        end else if (i_cfg_valid) begin
            r_key_count <= i_cfg_data;
        end
    end

    // zero keys acts as one, too many saturate
    always_comb begin
        if (r_key_count == 5'd0) begin
            n_n = KCNT_W'(1);
        end else if (32'(r_key_count) > MAX_KEYS) begin
            n_n = KCNT_W'(MAX_KEYS);
        end else begin
            n_n = KCNT_W'(r_key_count);
        end
    end

    assign s_from    = $signed({1'b0, r_cl[r_ch]});
    assign s_diff    = $signed({1'b0, r_cr[r_ch]}) - $signed({1'b0, r_cl[r_ch]});
    assign s_sum     = NW'(r_p1) + NW'(r_p2);
    assign s_dur_ext = NW'(r_dur);
    assign sat       = ($unsigned(r_nsum) >= (r_dabs << 8));
    assign div_ge    = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cur  <= TIME_BITS'(i_in_word.current_time);
            r_n    <= n_n;
            r_i    <= '0;
            r_left <= '0;
            r_ch   <= '0;
        end
        if (i_cmd.scan_step) begin
            r_left <= r_i;
            r_i    <= r_i + KEY_IDX_W'(1);
        end
        if (i_cmd.latch_l) begin
            r_tl <= r_rd_time;
            r_cl <= r_rd_color;
        end
        if (i_cmd.latch_r) begin
            r_cr  <= r_rd_color;
            r_dur <= $signed({1'b0, r_rd_time}) - $signed({1'b0, r_tl});
            r_num <= $signed({1'b0, r_cur}) - $signed({1'b0, r_tl});
        end
        if (i_cmd.mul) begin
            r_p1 <= s_from * r_dur;
            r_p2 <= s_diff * r_num;
        end
        // fold the sign of the duration into the numerator
        if (i_cmd.sum) begin
            if (r_dur < 0) begin
                r_nsum <= -s_sum;
                r_dabs <= $unsigned(-s_dur_ext);
            end else begin
                r_nsum <= s_sum;
                r_dabs <= $unsigned(s_dur_ext);
            end
        end
        if (i_cmd.chk) begin
            r_q   <= (r_nsum > 0 && sat) ? 8'd255 : 8'd0;
            r_rem <= $unsigned(r_nsum);
            r_dsh <= r_dabs << 7;
            r_k   <= 3'd7;
        end
        // restoring divide, one quotient bit per cycle
        if (i_cmd.div) begin
            if (div_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[6:0], div_ge};
            r_dsh <= r_dsh >> 1;
            r_k   <= r_k - 3'd1;
        end
        if (i_cmd.next) begin
            r_blend[r_ch] <= r_q;
            r_ch          <= r_ch + 2'd1;
        end
        if (i_cmd.out_load) begin
            unique case (i_cmd.out_sel)
                OSEL_LEFT: begin
                    r_out.color_argb          <= r_cl;
                    r_out.zero_duration_error <= 1'b0;
                end
                OSEL_ERR: begin
                    r_out.color_argb          <= r_cl;
                    r_out.zero_duration_error <= 1'b1;
                end
                OSEL_BLEND: begin
                    r_out.color_argb          <= r_blend;
                    r_out.zero_duration_error <= 1'b0;
                end
                default: begin
                    r_out.color_argb          <= r_cl;
                    r_out.zero_duration_error <= 1'b0;
                end
            endcase
        end
    end

    assign o_sts.scan_hit  = (r_rd_time >= r_cur);
    assign o_sts.scan_last = ((KCNT_W'(r_i) + KCNT_W'(1)) == r_n);
    assign o_sts.left_last = ((KCNT_W'(r_left) + KCNT_W'(1)) == r_n);
    assign o_sts.dur_zero  = (r_rd_time == r_tl);
    assign o_sts.early     = (r_nsum <= 0) || sat;
    assign o_sts.div_last  = (r_k == 3'd0);
    assign o_sts.ch_last   = (r_ch == 2'd3);

    assign o_out_word = r_out;

endmodule

`default_nettype wire

// ----- rtl/kci_ctrl.sv -----
// ----------------------------------------------------------------------------
// kci_ctrl
// sequencer for key writes, key scan, per-channel blend and result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kci_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_op,
    input  wire logic          i_out_ready,
    input  wire kci_pkg::t_sts i_sts,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output kci_pkg::t_cmd      o_cmd
);
    import kci_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_RD_L,
        S_LAT_L,
        S_LAT_R,
        S_MUL,
        S_SUM,
        S_CHK,
        S_DIV,
        S_NEXT,
        S_EMIT
    } t_state;

    t_state   r_state, n_state;
    t_out_sel r_out_sel, n_out_sel;
    logic     r_out_valid, n_out_valid;
    logic     out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_sel   = r_out_sel;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.rd_sel  = RSEL_SCAN;
        o_cmd.out_sel = r_out_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_op == OP_WRITE) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_sts.scan_hit) begin
                    n_state = S_RD_L;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    n_state = i_sts.scan_last ? S_RD_L : S_SCAN_RD;
                end
            end
            S_RD_L: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RSEL_LEFT;
                n_state      = S_LAT_L;
            end
            S_LAT_L: begin
                o_cmd.latch_l = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RSEL_RIGHT;
                if (i_sts.left_last) begin
                    n_out_sel = OSEL_LEFT;
                    n_state   = S_EMIT;
                end else begin
                    n_state = S_LAT_R;
                end
            end
            S_LAT_R: begin
                o_cmd.latch_r = 1'b1;
                if (i_sts.dur_zero) begin
                    n_out_sel = OSEL_ERR;
                    n_state   = S_EMIT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = i_sts.early ? S_NEXT : S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.next = 1'b1;
                if (i_sts.ch_last) begin
                    n_out_sel = OSEL_BLEND;
                    n_state   = S_EMIT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_sel   <= OSEL_LEFT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_sel   <= n_out_sel;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- rtl/keyframe_color_interpolator.sv -----
// timing: a write word is taken in S_IDLE; a query scans the keys (up to 16), reading and
// checking each, reads the left key and, unless it is the last, the right key, then blends
// each color channel by multiply, sum, check and 8-step divide, and loads the result
// throughput: one query at a time; no new word is taken until the query result is loaded
// a finished word waits in the output register while the next word is taken
// reset: synchronous active low, clears control and sets key_count to 1; key tables undefined
// ----------------------------------------------------------------------------
// keyframe_color_interpolator
// piecewise linear ARGB keyframe interpolation with exact integer blend
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "keyframe_color_interpolator_defines.svh"

module keyframe_color_interpolator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire kci_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output kci_pkg::t_out_word      o_out_word,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [4:0]         i_cfg_data
);
    import kci_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_acc_query;
    logic in_acc_write;
    logic out_held;

    assign o_cfg_ready = 1'b1;

    kci_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_op     (i_in_word.operation),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    kci_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_word  (o_out_word)
    );

    assign in_acc_query = i_in_valid && o_in_ready && (i_in_word.operation == OP_QUERY);
    assign in_acc_write = i_in_valid && o_in_ready && (i_in_word.operation == OP_WRITE);
    assign out_held     = o_out_valid && !i_out_ready && o_in_ready;

    // a query word makes the block busy
    `KCI_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, in_acc_query, !o_in_ready)
    // a write word leaves the block ready again in the next cycle
    `KCI_ASSERT_NEXT(a_write_quick, i_clk, i_rst_n, in_acc_write, o_in_ready)
    // a write never disturbs a pending result
    `KCI_ASSERT_NEXT(a_write_keeps_out, i_clk, i_rst_n, out_held, o_out_valid)

endmodule

`default_nettype wire
